FILE: rtl/dsa_pkg.sv
// ----------------------------------------------------------------------------
// dsa_pkg
// Shared widths, limits and codes of the descriptor slot allocator.
// ----------------------------------------------------------------------------
package dsa_pkg;

  // Field widths
  localparam int unsigned SlotW = 13;
  localparam int unsigned CntW  = 14;

  // Link memory depth: one link word per slot
  localparam int unsigned LinkDepth = 1 << SlotW;

  // Table limits
  localparam int unsigned MaxEntries   = 8192;
  localparam int unsigned MinEntries   = 512;
  localparam int unsigned FirstDynamic = 16;

  typedef logic [SlotW-1:0] slot_t;
  typedef logic [CntW-1:0]  cnt_t;

  // Request function codes
  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_e;

  // Response status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_BAD_FREE = 2'd2
  } status_e;

endpackage

FILE: rtl/dsa_if.sv
// ----------------------------------------------------------------------------
// dsa_if
// Valid/ready channels of the slot allocator: request and response.
// ----------------------------------------------------------------------------
interface dsa_req_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [dsa_pkg::SlotW-1:0]    slot_to_free;

  modport source (output valid, output func, output slot_to_free, input ready);
  modport sink   (input valid, input func, input slot_to_free, output ready);
endinterface

interface dsa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [dsa_pkg::SlotW-1:0]    granted_slot;
  logic [1:0]                   status;
  logic                         grew;
  logic [dsa_pkg::CntW-1:0]     slots_in_use;
  logic [dsa_pkg::CntW-1:0]     active_size;

  modport source (output valid, output granted_slot, output status, output grew,
                  output slots_in_use, output active_size, input ready);
  modport sink   (input valid, input granted_slot, input status, input grew,
                  input slots_in_use, input active_size, output ready);
endinterface

FILE: rtl/descriptor_slot_allocator.sv
// ----------------------------------------------------------------------------
// descriptor_slot_allocator
// Allocates and frees descriptor table slots. Freed slots go on a LIFO free
// list threaded through a link word memory; an empty list falls back to a
// sweep pointer that doubles the active table size as it reaches it.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Payload                                          Handshake
//  req_i    in   func, slot_to_free                               valid/ready
//  rsp_o    out  granted_slot, status, grew, slots_in_use,        valid/ready
//                active_size
//
// A free, a sweep allocate, a full table or a rejected free has its response
// registered at the accepting edge. A pop from the free list is answered from
// ST_POP, once the registered read of the link word memory gives the next head.
// A new request is taken in ST_IDLE while the response register is empty or
// being drained. Reset clears the control state; the link memory needs no clear.
//
module descriptor_slot_allocator (
  input  logic       clk_i,
  input  logic       rst_ni,
  dsa_req_if.sink    req_i,
  dsa_rsp_if.source  rsp_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_POP  = 2'b10
  } state_e;

  localparam dsa_pkg::cnt_t MaxCnt   = dsa_pkg::CntW'(dsa_pkg::MaxEntries);
  localparam dsa_pkg::cnt_t MinCnt   = dsa_pkg::CntW'(dsa_pkg::MinEntries);
  localparam dsa_pkg::cnt_t FirstCnt = dsa_pkg::CntW'(dsa_pkg::FirstDynamic);

  state_e         state_q, state_d;
  dsa_pkg::slot_t free_head_q, free_head_d;
  dsa_pkg::cnt_t  sweep_q, sweep_d;
  dsa_pkg::cnt_t  in_use_q, in_use_d;
  dsa_pkg::cnt_t  size_q, size_d;

  // Response register
  logic           out_valid_q, out_valid_d;
  logic           out_load;
  dsa_pkg::slot_t out_slot_q, out_slot_d;
  logic [1:0]     out_status_q, out_status_d;
  logic           out_grew_q, out_grew_d;

  // Link memory
  dsa_pkg::slot_t link_mem [dsa_pkg::LinkDepth];
  logic           mem_we, mem_re;
  dsa_pkg::slot_t mem_waddr, mem_wdata, mem_raddr, mem_rdata_q;

  logic           accept;
  logic [dsa_pkg::CntW:0] size_dbl;
  dsa_pkg::cnt_t  in_use_inc;

  assign req_i.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  assign size_dbl   = {size_q, 1'b0};
  assign in_use_inc = (in_use_q < MaxCnt) ? in_use_q + 1'b1 : in_use_q;

  // Request decode and state update
  always_comb begin
    state_d      = state_q;
    free_head_d  = free_head_q;
    sweep_d      = sweep_q;
    in_use_d     = in_use_q;
    size_d       = size_q;
    out_load     = 1'b0;
    out_slot_d   = out_slot_q;
    out_status_d = out_status_q;
    out_grew_d   = out_grew_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = req_i.slot_to_free;
    mem_wdata    = free_head_q;
    mem_raddr    = free_head_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_i.func == dsa_pkg::FUNC_ALLOC) begin
            if (free_head_q != '0) begin
              // pop: fetch the link word, finish next cycle
              mem_re  = 1'b1;
              state_d = ST_POP;
            end else if (sweep_q >= size_q && size_q >= MaxCnt) begin
              out_load     = 1'b1;
              out_slot_d   = '0;
              out_status_d = dsa_pkg::STAT_FULL;
              out_grew_d   = 1'b0;
            end else begin
              // sweep allocate, growing the table first if needed
              if (sweep_q >= size_q) begin
                size_d     = (size_dbl > {1'b0, MaxCnt}) ? MaxCnt : size_dbl[dsa_pkg::CntW-1:0];
                out_grew_d = 1'b1;
              end else begin
                out_grew_d = 1'b0;
              end
              out_load     = 1'b1;
              out_slot_d   = sweep_q[dsa_pkg::SlotW-1:0];
              out_status_d = dsa_pkg::STAT_OK;
              sweep_d      = sweep_q + 1'b1;
              in_use_d     = in_use_inc;
            end
          end else begin
            out_load   = 1'b1;
            out_slot_d = '0;
            out_grew_d = 1'b0;
            if ({1'b0, req_i.slot_to_free} < FirstCnt ||
                {1'b0, req_i.slot_to_free} >= sweep_q ||
                in_use_q <= FirstCnt) begin
              out_status_d = dsa_pkg::STAT_BAD_FREE;
            end else begin
              // push: link the slot to the old head
              out_status_d = dsa_pkg::STAT_OK;
              mem_we       = 1'b1;
              free_head_d  = req_i.slot_to_free;
              in_use_d     = in_use_q - 1'b1;
            end
          end
        end
      end
      ST_POP: begin
        out_load     = 1'b1;
        out_slot_d   = free_head_q;
        out_status_d = dsa_pkg::STAT_OK;
        out_grew_d   = 1'b0;
        free_head_d  = mem_rdata_q;
        in_use_d     = in_use_inc;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Response valid: set on load, cleared when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      free_head_q <= '0;
      sweep_q     <= FirstCnt;
      in_use_q    <= FirstCnt;
      size_q      <= MinCnt;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      sweep_q     <= sweep_d;
      in_use_q    <= in_use_d;
      size_q      <= size_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Response payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_slot_q   <= out_slot_d;
      out_status_q <= out_status_d;
      out_grew_q   <= out_grew_d;
    end
  end

  // Link word memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= link_mem[mem_raddr];
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.granted_slot = out_slot_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.grew         = out_grew_q;
  assign rsp_o.slots_in_use = in_use_q;
  assign rsp_o.active_size  = size_q;

endmodule

FILE: rtl/dsa_checker.sv
// ----------------------------------------------------------------------------
// dsa_checker
// Port-level checks of the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module dsa_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_valid_i,
  input  logic                      req_ready_i,
  input  logic                      req_func_i,
  input  logic [dsa_pkg::SlotW-1:0] req_slot_i,
  input  logic                      rsp_valid_i,
  input  logic                      rsp_ready_i,
  input  logic [dsa_pkg::SlotW-1:0] rsp_slot_i,
  input  logic [1:0]                rsp_status_i,
  input  logic                      rsp_grew_i,
  input  logic [dsa_pkg::CntW-1:0]  rsp_size_i
);

  // Stalled response stays up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  // Failed requests grant nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != dsa_pkg::STAT_OK |-> rsp_slot_i == '0 && !rsp_grew_i)
    else $error("slot or growth reported on a failed request");

  // A free below the dynamic range is rejected in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && req_func_i == dsa_pkg::FUNC_FREE &&
    {1'b0, req_slot_i} < dsa_pkg::CntW'(dsa_pkg::FirstDynamic)
    |=> rsp_valid_i && rsp_status_i == dsa_pkg::STAT_BAD_FREE)
    else $error("reserved slot free not rejected");

  // Table size stays within its limits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_size_i >= dsa_pkg::CntW'(dsa_pkg::MinEntries) &&
                    rsp_size_i <= dsa_pkg::CntW'(dsa_pkg::MaxEntries))
    else $error("active size out of range");

endmodule

bind descriptor_slot_allocator dsa_checker u_dsa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .req_func_i   (req_i.func),
  .req_slot_i   (req_i.slot_to_free),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_slot_i   (rsp_o.granted_slot),
  .rsp_status_i (rsp_o.status),
  .rsp_grew_i   (rsp_o.grew),
  .rsp_size_i   (rsp_o.active_size)
);

FILE: tb/descriptor_slot_allocator_tb.sv
// ----------------------------------------------------------------------------
// descriptor_slot_allocator_tb
// Self-checking bench for the slot allocator. A shadow of the free list, the
// sweep pointer, the in-use count and the table size predicts every response.
// Stimulus runs through illegal frees, a well-formed alloc/free mix, double
// frees and random noise on the corrupted list. Both channels idle at random.
// ----------------------------------------------------------------------------
module descriptor_slot_allocator_tb;

  localparam int unsigned CycleLimit  = 3_000_000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned RandomItems = 400;
  localparam int unsigned QueueDepth  = 4;

  typedef struct {
    dsa_pkg::func_e func;
    dsa_pkg::slot_t slot;
  } slot_req_t;

  typedef struct packed {
    dsa_pkg::slot_t   slot;
    dsa_pkg::status_e status;
    logic             grew;
    dsa_pkg::cnt_t    in_use;
    dsa_pkg::cnt_t    size;
  } slot_rsp_t;

  logic clk;
  logic rst_n;

  dsa_req_if req_if ();
  dsa_rsp_if rsp_if ();

  descriptor_slot_allocator u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Shadow allocator state
  dsa_pkg::slot_t free_head;
  dsa_pkg::cnt_t  sweep_ptr;
  dsa_pkg::cnt_t  used_cnt;
  dsa_pkg::cnt_t  tbl_size;
  dsa_pkg::slot_t link_mem [dsa_pkg::LinkDepth];

  slot_req_t      pending_q[$];
  slot_rsp_t      expected_q[$];
  dsa_pkg::slot_t held_slots[$];
  int unsigned    hi_slot;
  logic           req_taken;
  int unsigned    err_cnt;
  int unsigned    cyc;

  // Idle control
  int unsigned req_gap;
  int unsigned rsp_stall;
  logic        calm;
  int unsigned calm_left;

  // Apply one request to the shadow state and return the response it causes
  function automatic slot_rsp_t allocate_or_free(slot_req_t r);
    slot_rsp_t   res;
    int unsigned dbl;
    res        = '0;
    res.status = dsa_pkg::STAT_OK;
    if (r.func == dsa_pkg::FUNC_ALLOC) begin
      if (free_head != '0) begin
        // pop the LIFO list
        res.slot  = free_head;
        free_head = link_mem[free_head];
      end else if (sweep_ptr >= tbl_size && tbl_size >= dsa_pkg::MaxEntries) begin
        res.status = dsa_pkg::STAT_FULL;
      end else begin
        if (sweep_ptr >= tbl_size) begin
          dbl      = 2 * tbl_size;
          tbl_size = (dbl > dsa_pkg::MaxEntries) ? dsa_pkg::cnt_t'(dsa_pkg::MaxEntries)
                                                 : dsa_pkg::cnt_t'(dbl);
          res.grew = 1'b1;
        end
        res.slot  = sweep_ptr[dsa_pkg::SlotW-1:0];
        sweep_ptr = sweep_ptr + 1'b1;
      end
      // count saturates at the table maximum
      if (res.status == dsa_pkg::STAT_OK && used_cnt < dsa_pkg::MaxEntries)
        used_cnt = used_cnt + 1'b1;
    end else if (r.slot < dsa_pkg::FirstDynamic || r.slot >= sweep_ptr ||
                 used_cnt <= dsa_pkg::FirstDynamic) begin
      res.status = dsa_pkg::STAT_BAD_FREE;
    end else begin
      used_cnt       = used_cnt - 1'b1;
      link_mem[r.slot] = free_head;
      free_head      = r.slot;
    end
    res.in_use = used_cnt;
    res.size   = tbl_size;
    return res;
  endfunction

  // Idle length: mostly none or short, a few long; calm stretches have none
  function automatic int unsigned pick_idle();
    int unsigned n;
    if (calm_left == 0) begin
      calm      = ~calm;
      calm_left = $urandom_range(20, 80);
    end
    calm_left--;
    n = $urandom_range(0, 99);
    if (calm || n < 65) return 0;
    if (n < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
      err_cnt++;
    end
  endtask

  // Push one request; keep the pending queue short so choices track state
  task automatic queue_req(dsa_pkg::func_e f, dsa_pkg::slot_t s);
    slot_req_t r;
    while (pending_q.size() >= QueueDepth) @(posedge clk);
    r.func = f;
    r.slot = s;
    pending_q.push_back(r);
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0 || req_if.valid || expected_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic free_held_slot();
    int unsigned    idx;
    dsa_pkg::slot_t s;
    idx = $urandom_range(0, held_slots.size() - 1);
    s   = held_slots[idx];
    held_slots.delete(idx);
    queue_req(dsa_pkg::FUNC_FREE, s);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cyc++;
    if (cyc > CycleLimit) begin
      $display("%0t: cycle limit reached", $time);
      $display("descriptor_slot_allocator: mismatch");
      $finish;
    end
  end

  // Request driver
  always @(negedge clk) begin
    slot_req_t nxt;
    if (rst_n && (!req_if.valid || req_taken)) begin
      if (req_gap > 0) begin
        req_gap--;
        req_if.valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        nxt = pending_q.pop_front();
        req_if.valid        <= 1'b1;
        req_if.func         <= nxt.func;
        req_if.slot_to_free <= nxt.slot;
        req_gap = pick_idle();
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Response backpressure
  always @(negedge clk) begin
    if (rst_n) begin
      if (rsp_stall > 0) begin
        rsp_stall--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_stall = ($urandom_range(0, 5) == 0) ? pick_idle() : 0;
        rsp_if.ready <= (rsp_stall == 0);
      end
    end
  end

  // Monitor: predict on each request transaction, check each response
  always @(posedge clk) begin
    slot_req_t r;
    slot_rsp_t e;
    if (rst_n) begin
      req_taken = req_if.valid && req_if.ready;
      if (req_taken) begin
        r.func = dsa_pkg::func_e'(req_if.func);
        r.slot = req_if.slot_to_free;
        expected_q.push_back(allocate_or_free(r));
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected response, got slot %0d status %0d", $time,
                   rsp_if.granted_slot, rsp_if.status);
          err_cnt++;
        end else begin
          e = expected_q.pop_front();
          check_field("granted_slot", 32'(e.slot), 32'(rsp_if.granted_slot));
          check_field("status", 32'(e.status), 32'(rsp_if.status));
          check_field("grew", 32'(e.grew), 32'(rsp_if.grew));
          check_field("slots_in_use", 32'(e.in_use), 32'(rsp_if.slots_in_use));
          check_field("active_size", 32'(e.size), 32'(rsp_if.active_size));
          // a granted slot becomes a candidate for a later free
          if (e.status == dsa_pkg::STAT_OK && e.slot != '0) begin
            held_slots.push_back(e.slot);
            if (32'(e.slot) > hi_slot) hi_slot = 32'(e.slot);
          end
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int unsigned    n;
    dsa_pkg::slot_t s;
    dsa_pkg::slot_t dup;
    rst_n               = 1'b0;
    req_if.valid        = 1'b0;
    req_if.func         = dsa_pkg::FUNC_ALLOC;
    req_if.slot_to_free = '0;
    rsp_if.ready        = 1'b0;
    free_head = '0;
    sweep_ptr = dsa_pkg::cnt_t'(dsa_pkg::FirstDynamic);
    used_cnt  = dsa_pkg::cnt_t'(dsa_pkg::FirstDynamic);
    tbl_size  = dsa_pkg::cnt_t'(dsa_pkg::MinEntries);
    hi_slot   = 0;
    req_taken = 1'b0;
    err_cnt   = 0;
    cyc       = 0;
    req_gap   = 0;
    rsp_stall = 0;
    calm      = 1'b0;
    calm_left = 30;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: illegal frees, sweep, pops, empty-count free
    queue_req(dsa_pkg::FUNC_FREE, '0);
    queue_req(dsa_pkg::FUNC_FREE, dsa_pkg::slot_t'(dsa_pkg::FirstDynamic - 1));
    queue_req(dsa_pkg::FUNC_FREE, dsa_pkg::slot_t'(dsa_pkg::FirstDynamic));
    queue_req(dsa_pkg::FUNC_FREE, '1);
    queue_req(dsa_pkg::FUNC_ALLOC, '1);
    queue_req(dsa_pkg::FUNC_ALLOC, '0);
    queue_req(dsa_pkg::FUNC_ALLOC, 13'h0aaa);
    queue_req(dsa_pkg::FUNC_FREE, dsa_pkg::slot_t'(dsa_pkg::FirstDynamic + 1));
    queue_req(dsa_pkg::FUNC_FREE, dsa_pkg::slot_t'(dsa_pkg::FirstDynamic + 2));
    queue_req(dsa_pkg::FUNC_ALLOC, 13'h1555);
    queue_req(dsa_pkg::FUNC_ALLOC, '0);
    queue_req(dsa_pkg::FUNC_ALLOC, '0);
    queue_req(dsa_pkg::FUNC_FREE, dsa_pkg::slot_t'(dsa_pkg::FirstDynamic + 4));
    for (int i = 0; i < 4; i++)
      queue_req(dsa_pkg::FUNC_FREE, dsa_pkg::slot_t'(dsa_pkg::FirstDynamic + i));
    queue_req(dsa_pkg::FUNC_FREE, dsa_pkg::slot_t'(dsa_pkg::FirstDynamic + 1));
    wait_idle();
    held_slots.delete();

    // Random: mostly well-formed allocs and frees, some illegal frees
    for (int unsigned i = 0; i < RandomItems; i++) begin
      n = $urandom_range(0, 99);
      if (n < 55 || (n < 85 && held_slots.size() == 0)) begin
        queue_req(dsa_pkg::FUNC_ALLOC, dsa_pkg::slot_t'($urandom));
      end else if (n < 85) begin
        free_held_slot();
      end else if (n < 92 && hi_slot + 24 <= dsa_pkg::LinkDepth - 1) begin
        // beyond the sweep pointer, with margin for queued allocs
        queue_req(dsa_pkg::FUNC_FREE,
                  dsa_pkg::slot_t'($urandom_range(hi_slot + 24, dsa_pkg::LinkDepth - 1)));
      end else begin
        queue_req(dsa_pkg::FUNC_FREE,
                  dsa_pkg::slot_t'($urandom_range(0, dsa_pkg::FirstDynamic - 1)));
      end
    end
    wait_idle();

    // Double free of a granted slot, then pops of the duplicated entry
    if (held_slots.size() != 0) begin
      dup = held_slots[$urandom_range(0, held_slots.size() - 1)];
      queue_req(dsa_pkg::FUNC_FREE, dup);
      queue_req(dsa_pkg::FUNC_FREE, dup);
      for (int i = 0; i < 3; i++) queue_req(dsa_pkg::FUNC_ALLOC, dsa_pkg::slot_t'($urandom));
      queue_req(dsa_pkg::FUNC_FREE, dup);
    end

    // Noise on the corrupted list: any free index
    for (int i = 0; i < 30; i++) begin
      s = dsa_pkg::slot_t'($urandom_range(0, dsa_pkg::LinkDepth - 1));
      if ($urandom_range(0, 1) == 0) queue_req(dsa_pkg::FUNC_ALLOC, s);
      else queue_req(dsa_pkg::FUNC_FREE, s);
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    if (expected_q.size() != 0) begin
      $display("%0t: %0d responses never arrived", $time, expected_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("descriptor_slot_allocator: match");
    end else begin
      $display("descriptor_slot_allocator: mismatch");
    end
    $finish;
  end

endmodule
